### rtl/core/presence_and_ambiguous_set_table_top_assert.svh
// ----------------------------------------------------------------------------
// Presence and ambiguous set table assertion macros
// Concurrent checks that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef PRESENCE_AND_AMBIGUOUS_SET_TABLE_TOP_ASSERT_SVH
`define PRESENCE_AND_AMBIGUOUS_SET_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PAST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define PAST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define PAST_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PAST_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/pastbl_pkg.sv
// ----------------------------------------------------------------------------
// Presence and ambiguous set table package
// Request and result types, op and status codes shared by the table logic.
// ----------------------------------------------------------------------------
`default_nettype none

package pastbl_pkg;

  localparam int KEY_BITS   = 56;
  localparam int OP_BITS    = 3;
  localparam int LIMIT_BITS = 6;
  localparam int STAT_BITS  = 3;
  localparam int TOTAL_BITS = 6;

  localparam logic [OP_BITS-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_BITS-1:0] OP_EXTRACT   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_AMBIG     = 3'd2;
  localparam logic [OP_BITS-1:0] OP_CLEAR     = 3'd3;
  localparam logic [OP_BITS-1:0] OP_READ_PRES = 3'd4;
  localparam logic [OP_BITS-1:0] OP_READ_AMB  = 3'd5;

  localparam logic [STAT_BITS-1:0] ST_ADDED      = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_HELD       = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL       = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_REMOVED    = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [STAT_BITS-1:0] ST_CLEARED    = 3'd5;
  localparam logic [STAT_BITS-1:0] ST_ENTRY      = 3'd6;
  localparam logic [STAT_BITS-1:0] ST_EMPTY_READ = 3'd7;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [KEY_BITS-1:0]   item_key;
    logic [LIMIT_BITS-1:0] read_limit;
  } pastbl_in_t;

  typedef struct packed {
    logic [STAT_BITS-1:0]  status;
    logic [KEY_BITS-1:0]   entry_key;
    logic                  last;
    logic [TOTAL_BITS-1:0] present_total;
    logic [TOTAL_BITS-1:0] ambiguous_total;
  } pastbl_out_t;

endpackage

`default_nettype wire

### rtl/core/presence_and_ambiguous_set_table_top.sv
// ----------------------------------------------------------------------------
// Presence and ambiguous set table
// Two bounded key sets held in RAM, searched and updated by a sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request's work is done. Each set is scanned one entry per cycle
// through its RAM read port for insert, ambiguous and extract; an extract
// hit then moves the last entry into the freed slot with one more read and a
// write. A read fetches min(count, read_limit) entries and raises no busy when
// that minimum is zero; clear and the unused op codes do not raise busy either.
// Results come out of a register in the cycle after they are formed, each on
// out_valid for exactly one cycle; the receiver cannot stall, and a read
// streams its entries on consecutive cycles with last on the final one. The
// final result of a request may appear in the cycle where busy has already
// dropped. No clearing pass is needed after reset: only entries below the
// count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

`include "presence_and_ambiguous_set_table_top_assert.svh"

module presence_and_ambiguous_set_table_top #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire pastbl_pkg::pastbl_in_t  in_req,
  output logic                         out_valid,
  output pastbl_pkg::pastbl_out_t      out_res
);

  import pastbl_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_READ    = 3'd2;
  localparam logic [2:0] S_MOVE_RD = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       pres_cnt_r, pres_cnt_nxt;
  logic [CW-1:0]       amb_cnt_r, amb_cnt_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [OP_BITS-1:0]  op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic                sel_amb_r, sel_amb_nxt;
  logic [AW-1:0]       pend_idx_r, pend_idx_nxt;
  logic [AW-1:0]       hit_idx_r, hit_idx_nxt;
  pastbl_out_t         out_res_r, out_res_nxt;

  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic [KEY_BITS-1:0] wdata;
  logic                we_p, we_a;
  logic [KEY_BITS-1:0] rdata_p, rdata_a, rdata;
  logic [CW-1:0]       cur_cnt;
  logic [CW-1:0]       last_idx;

  pastbl_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(KEY_BITS)) u_pres_ram (
    .clk   (clk),
    .we    (we_p),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_p)
  );

  pastbl_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(KEY_BITS)) u_amb_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  assign rdata    = sel_amb_r ? rdata_a : rdata_p;
  assign cur_cnt  = sel_amb_r ? amb_cnt_r : pres_cnt_r;
  assign last_idx = pres_cnt_r - 1'b1;

  always_comb begin
    logic                 emit;
    logic [STAT_BITS-1:0] st;
    logic [KEY_BITS-1:0]  ekey;
    logic                 lst;
    logic [CW-1:0]        acc_cnt;
    logic [NW-1:0]        lim_ext;
    logic [CW-1:0]        acc_n;

    state_nxt    = state_r;
    pres_cnt_nxt = pres_cnt_r;
    amb_cnt_nxt  = amb_cnt_r;
    iss_nxt      = iss_r;
    pend_nxt     = pend_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    n_nxt        = n_r;
    sel_amb_nxt  = sel_amb_r;
    pend_idx_nxt = pend_idx_r;
    hit_idx_nxt  = hit_idx_r;

    raddr = iss_r[AW-1:0];
    waddr = cur_cnt[AW-1:0];
    wdata = key_r;
    we_p  = 1'b0;
    we_a  = 1'b0;

    emit = 1'b0;
    st   = ST_ADDED;
    ekey = '0;
    lst  = 1'b1;

    acc_cnt = (in_req.op == OP_READ_AMB) ? amb_cnt_r : pres_cnt_r;
    lim_ext = NW'(in_req.read_limit);
    acc_n   = (lim_ext < NW'(acc_cnt)) ? CW'(lim_ext) : acc_cnt;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = in_req.op;
          key_nxt     = in_req.item_key;
          n_nxt       = acc_n;
          sel_amb_nxt = (in_req.op == OP_AMBIG) || (in_req.op == OP_READ_AMB);
          iss_nxt     = '0;
          pend_nxt    = 1'b0;
          case (in_req.op)
            OP_INSERT, OP_EXTRACT, OP_AMBIG: begin
              state_nxt = S_SCAN;
            end
            OP_CLEAR: begin
              pres_cnt_nxt = '0;
              amb_cnt_nxt  = '0;
              emit         = 1'b1;
              st           = ST_CLEARED;
            end
            OP_READ_PRES, OP_READ_AMB: begin
              if (acc_n == '0) begin
                emit = 1'b1;
                st   = ST_EMPTY_READ;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (pend_r && (rdata == key_r)) begin
          pend_nxt = 1'b0;
          if (op_r == OP_EXTRACT) begin
            hit_idx_nxt = pend_idx_r;
            state_nxt   = S_MOVE_RD;
          end else begin
            emit      = 1'b1;
            st        = ST_HELD;
            state_nxt = S_IDLE;
          end
        end else if (iss_r < cur_cnt) begin
          // one read issued per cycle, compared when the data returns
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_r[AW-1:0];
          iss_nxt      = iss_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
          emit      = 1'b1;
          if (op_r == OP_EXTRACT) begin
            st = ST_NOT_FOUND;
          end else if (cur_cnt >= MAX_CNT) begin
            st = ST_FULL;
          end else begin
            st = ST_ADDED;
            if (sel_amb_r) begin
              we_a        = 1'b1;
              amb_cnt_nxt = amb_cnt_r + 1'b1;
            end else begin
              we_p         = 1'b1;
              pres_cnt_nxt = pres_cnt_r + 1'b1;
            end
          end
        end
      end

      S_MOVE_RD: begin
        raddr     = last_idx[AW-1:0];
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        // last entry fills the hole left by the hit
        we_p         = 1'b1;
        waddr        = hit_idx_r;
        wdata        = rdata_p;
        pres_cnt_nxt = last_idx;
        emit         = 1'b1;
        st           = ST_REMOVED;
        state_nxt    = S_IDLE;
      end

      S_READ: begin
        if (pend_r) begin
          emit = 1'b1;
          st   = ST_ENTRY;
          ekey = rdata;
          lst  = (iss_r == n_r);
        end
        if (iss_r < n_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_r[AW-1:0];
          iss_nxt      = iss_r + 1'b1;
        end else if (pend_r) begin
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt               = emit;
    out_res_nxt.status          = st;
    out_res_nxt.entry_key       = ekey;
    out_res_nxt.last            = lst;
    out_res_nxt.present_total   = TOTAL_BITS'(pres_cnt_nxt);
    out_res_nxt.ambiguous_total = TOTAL_BITS'(amb_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pres_cnt_r  <= '0;
      amb_cnt_r   <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pres_cnt_r  <= pres_cnt_nxt;
      amb_cnt_r   <= amb_cnt_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    n_r        <= n_nxt;
    sel_amb_r  <= sel_amb_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `PAST_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1,
                     (pres_cnt_r <= MAX_CNT) && (amb_cnt_r <= MAX_CNT))
  `PAST_ASSERT_NEXT(a_read_stream, clk, rst_n, out_valid && !out_res.last,
                    out_valid && (out_res.status == ST_ENTRY))
  `PAST_ASSERT_NEXT(a_clear, clk, rst_n, start && !busy && (in_req.op == OP_CLEAR),
                    out_valid && (out_res.status == ST_CLEARED) &&
                    (pres_cnt_r == '0) && (amb_cnt_r == '0))

endmodule

`default_nettype wire

### rtl/core/pastbl_ram.sv
// ----------------------------------------------------------------------------
// Set table storage
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pastbl_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 56,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
